// File: rtl/core/pair_energy_accumulator_unit_assert.svh
// Assertion macros shared by the pair energy accumulator RTL.
`ifndef PAIR_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH
`define PAIR_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pair energy accumulator: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pair energy accumulator: next-cycle check failed");

`endif

// File: rtl/core/pea_pkg.sv
// Shared types and constants of the pair energy accumulator.
`timescale 1ns / 1ps
package pea_pkg;

    localparam int COEF_W     = 32;
    localparam int DEN_W      = 35;
    localparam int MAG_W      = 34;
    localparam int PROD_W     = 68;
    localparam int SUM_W      = 64;
    localparam int ADD_W      = 66;
    localparam int REM_W      = 37;
    localparam int CNT_W      = 7;
    localparam int MUL_HALF   = 34;
    localparam int MUL_STEPS  = 68;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 34;

    // Operations of the shared serial unit.
    typedef enum logic [1:0] {
        OP_MULADD = 2'd0,
        OP_DIV    = 2'd1,
        OP_SQRT   = 2'd2
    } t_op;

    // Request to the serial unit, sampled when start is high.
    typedef struct packed {
        logic               start;
        t_op                op;
        logic [MAG_W-1:0]   a1;
        logic [MAG_W-1:0]   b1;
        logic [MAG_W-1:0]   a2;
        logic [MAG_W-1:0]   b2;
        logic [PROD_W-1:0]  num;
        logic [MAG_W-1:0]   dvs;
    } t_unit_req;

    // One term handed to the accumulator.
    typedef struct packed {
        logic               update;
        logic               skip;
        logic               neg;
        logic               last;
        logic [ADD_W-1:0]   mag;
    } t_acc_req;

endpackage

// File: rtl/core/pea_serial_unit.sv
// Bit-serial multiply-add, restoring divider and restoring square root.
`timescale 1ns / 1ps
module pea_serial_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pea_pkg::t_unit_req         i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [pea_pkg::PROD_W-1:0] o_result
);
    import pea_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_op               r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0] r_mcand, n_mcand;
    logic [MAG_W-1:0]  r_mplier, n_mplier;
    logic [MAG_W-1:0]  r_a2, n_a2;
    logic [MAG_W-1:0]  r_b2, n_b2;
    logic [PROD_W-1:0] r_src, n_src;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_dvs, n_dvs;

    logic [MAG_W:0]    w_dtrial;
    logic [MAG_W+1:0]  w_ddiff;
    logic              w_dge;
    logic [REM_W-1:0]  w_strial;
    logic [REM_W:0]    w_sdiff;
    logic              w_sge;

    // One divider step: bring down one numerator bit and try the divisor.
    assign w_dtrial = {r_rem[MAG_W-1:0], r_src[PROD_W-1]};
    assign w_ddiff  = {1'b0, w_dtrial} - {2'b00, r_dvs};
    assign w_dge    = ~w_ddiff[MAG_W+1];

    // One square-root step: bring down two radicand bits and try 4*root+1.
    assign w_strial = {r_rem[REM_W-3:0], r_src[PROD_W-1:PROD_W-2]};
    assign w_sdiff  = {1'b0, w_strial} - {2'b00, r_acc[MAG_W-1:0], 2'b01};
    assign w_sge    = ~w_sdiff[REM_W];

    // Next-state logic of the unit.
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_op     = r_op;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_a2     = r_a2;
        n_b2     = r_b2;
        n_src    = r_src;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_op     = i_req.op;
            n_cnt    = '0;
            n_acc    = '0;
            n_mcand  = {{(PROD_W-MAG_W){1'b0}}, i_req.a1};
            n_mplier = i_req.b1;
            n_a2     = i_req.a2;
            n_b2     = i_req.b2;
            n_rem    = '0;
            n_dvs    = i_req.dvs;
            if (i_req.op == OP_DIV) begin
                n_src = {i_req.num[SUM_W-1:0], {(PROD_W-SUM_W){1'b0}}};
            end else begin
                n_src = i_req.num;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + CNT_W'(1);
            unique case (r_op)
                OP_MULADD: begin
                    n_acc = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
                    if (r_cnt == CNT_W'(MUL_HALF-1)) begin
                        n_mcand  = {{(PROD_W-MAG_W){1'b0}}, r_a2};
                        n_mplier = r_b2;
                    end else begin
                        n_mcand  = {r_mcand[PROD_W-2:0], 1'b0};
                        n_mplier = {1'b0, r_mplier[MAG_W-1:1]};
                    end
                    if (r_cnt == CNT_W'(MUL_STEPS-1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                OP_DIV: begin
                    n_acc = {r_acc[PROD_W-2:0], w_dge};
                    n_src = {r_src[PROD_W-2:0], 1'b0};
                    if (w_dge) begin
                        n_rem = {{(REM_W-MAG_W){1'b0}}, w_ddiff[MAG_W-1:0]};
                    end else begin
                        n_rem = {{(REM_W-MAG_W){1'b0}}, w_dtrial[MAG_W-1:0]};
                    end
                    if (r_cnt == CNT_W'(DIV_STEPS-1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                OP_SQRT: begin
                    n_acc = {r_acc[PROD_W-2:0], w_sge};
                    n_src = {r_src[PROD_W-3:0], 2'b00};
                    n_rem = w_sge ? w_sdiff[REM_W-1:0] : w_strial;
                    if (r_cnt == CNT_W'(SQRT_STEPS-1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_a2     <= n_a2;
        r_b2     <= n_b2;
        r_src    <= n_src;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// File: rtl/core/pea_accum.sv
// Saturating running sum, sticky flags and the result register.
`timescale 1ns / 1ps
module pea_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pea_pkg::t_acc_req         i_req,
    input  logic                      i_out_ready,
    output logic                      o_out_hold,
    output logic                      o_out_valid,
    output logic [pea_pkg::SUM_W-1:0] o_total,
    output logic                      o_zero_den,
    output logic                      o_saturated
);
    import pea_pkg::*;

    logic [SUM_W-1:0]    r_sum;
    logic                r_zd;
    logic                r_ov;
    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_total;
    logic                r_out_zd;
    logic                r_out_ov;

    logic [PROD_W-1:0]   w_sext;
    logic [PROD_W-1:0]   w_mext;
    logic [PROD_W-1:0]   w_raw;
    logic                w_clip;
    logic [SUM_W-1:0]    w_sum;
    logic                w_zd;
    logic                w_ov;

    // Wide add, then clip to the signed 64-bit range.
    assign w_sext = {{(PROD_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
    assign w_mext = {{(PROD_W-ADD_W){1'b0}}, i_req.mag};
    assign w_raw  = i_req.neg ? (w_sext - w_mext) : (w_sext + w_mext);
    assign w_clip = (w_raw[PROD_W-1:SUM_W-1] != '0) && (w_raw[PROD_W-1:SUM_W-1] != '1);

    always_comb begin
        w_sum = r_sum;
        w_zd  = r_zd;
        w_ov  = r_ov;
        if (i_req.skip) begin
            w_zd = 1'b1;
        end else if (w_clip) begin
            w_ov  = 1'b1;
            w_sum = w_raw[PROD_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum = w_raw[SUM_W-1:0];
        end
    end

    // The sum and its flags clear when the last item of a set is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_zd        <= 1'b0;
            r_ov        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_req.update) begin
                if (i_req.last) begin
                    r_sum       <= '0;
                    r_zd        <= 1'b0;
                    r_ov        <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_sum <= w_sum;
                    r_zd  <= w_zd;
                    r_ov  <= w_ov;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_req.update && i_req.last) begin
            r_out_total <= w_sum;
            r_out_zd    <= w_zd;
            r_out_ov    <= w_ov;
        end
    end

    assign o_out_hold  = r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_total     = r_out_total;
    assign o_zero_den  = r_out_zd;
    assign o_saturated = r_out_ov;

endmodule

// File: rtl/core/pair_energy_accumulator_unit.sv
// Top level of the pair energy accumulator: input capture, sequencer and term assembly.
// Standard mode: capture, setup and issue, then a serial multiply and a serial divide, then
// accumulate. Corrected mode: two serial squares and two serial roots, then term and accumulate.
// A zero denominator in standard mode skips the serial unit; otherwise the shared serial unit
// sets the rate, and a new item is taken only in the idle state.
// A result appears in the cycle after the last item's term is added.
// Synchronous active-low reset clears the sum, the flags, the mode, the state and the result valid bit.
`timescale 1ns / 1ps
module pair_energy_accumulator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,     // correction_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coef_ab, coef_ba, energy_occ_i, energy_occ_j, energy_virt_a, energy_virt_b
    input  logic [191:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // single_weight
    input  logic         s_axis_tlast,   // last_term
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // energy_total, zero_denominator, saturated, zero fill
    output logic [71:0]  m_axis_tdata
);
    import pea_pkg::*;

    `include "pair_energy_accumulator_unit_assert.svh"

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PREP  = 11'b00000000010,
        S_ISSUE = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_H1SQ  = 11'b00000100000,
        S_H1RT  = 11'b00001000000,
        S_H2SQ  = 11'b00010000000,
        S_H2RT  = 11'b00100000000,
        S_TERM  = 11'b01000000000,
        S_ACC   = 11'b10000000000
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_mode;
    logic signed [COEF_W-1:0]  r_tab, r_tba, r_ei, r_ej, r_ea, r_eb;
    logic                      r_single, r_last;
    logic signed [DEN_W-1:0]   r_den;
    logic signed [COEF_W+1:0]  r_x;
    logic signed [COEF_W:0]    r_d2;
    logic [MAG_W-1:0]          r_h1, r_h2;
    logic [ADD_W-1:0]          r_add_mag, n_add_mag;
    logic                      r_add_neg, n_add_neg;
    logic                      r_add_skip, n_add_skip;

    t_unit_req                 w_req;
    t_acc_req                  w_acc;
    logic                      w_busy, w_done;
    logic [PROD_W-1:0]         w_res;
    logic                      w_hold, w_fire;

    logic [DEN_W-1:0]          w_dabs;
    logic [MAG_W-1:0]          w_dm, w_tabm, w_xm, w_t2m, w_d2m;
    logic                      w_std_neg;
    logic [DEN_W+3:0]          w_den_ext, w_t4;
    logic [DEN_W+1:0]          w_term, w_term_abs;
    logic [COEF_W:0]           w_d2abs;
    logic [COEF_W+1:0]         w_xabs;

    // Configuration register; always ready.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Magnitudes of the prepared operands.
    assign w_dabs    = r_den[DEN_W-1] ? (-r_den) : r_den;
    assign w_dm      = w_dabs[MAG_W-1:0];
    assign w_tabm    = {2'b00, (r_tab[COEF_W-1] ? (-r_tab) : r_tab)};
    assign w_xabs    = r_x[COEF_W+1] ? (-r_x) : r_x;
    assign w_xm      = w_xabs;
    assign w_t2m     = {w_tabm[MAG_W-2:0], 1'b0};
    assign w_d2abs   = r_d2[COEF_W] ? (-r_d2) : r_d2;
    assign w_d2m     = {w_d2abs, 1'b0};
    assign w_std_neg = (r_tab[COEF_W-1] ^ r_x[COEF_W+1]) ^ r_den[DEN_W-1];

    // Corrected term: floor((-3*den - 2*h1 - h2) / 4).
    assign w_den_ext  = {{4{r_den[DEN_W-1]}}, r_den};
    assign w_t4       = '0 - w_den_ext - {w_den_ext[DEN_W+2:0], 1'b0}
                        - {4'b0000, r_h1, 1'b0} - {5'b00000, r_h2};
    assign w_term     = w_t4[DEN_W+3:2];
    assign w_term_abs = w_term[DEN_W+1] ? ('0 - w_term) : w_term;

    assign w_fire = (r_state == S_ACC) && !(r_last && w_hold);

    // Sequencer and serial unit requests.
    always_comb begin
        n_state    = r_state;
        n_add_mag  = r_add_mag;
        n_add_neg  = r_add_neg;
        n_add_skip = r_add_skip;
        w_req       = '0;
        w_req.op    = OP_MULADD;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                n_add_skip = 1'b0;
                if (!r_mode && (r_den == '0)) begin
                    n_add_skip = 1'b1;
                    n_add_mag  = '0;
                    n_add_neg  = 1'b0;
                    n_state    = S_ACC;
                end else if (!r_mode) begin
                    w_req.start = 1'b1;
                    w_req.a1    = w_tabm;
                    w_req.b1    = w_xm;
                    n_state     = S_MUL;
                end else begin
                    w_req.start = 1'b1;
                    w_req.a1    = w_dm;
                    w_req.b1    = w_dm;
                    w_req.a2    = w_t2m;
                    w_req.b2    = w_t2m;
                    n_state     = S_H1SQ;
                end
            end
            S_MUL: begin
                if (w_done) begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_DIV;
                    w_req.num   = w_res;
                    w_req.dvs   = w_dm;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_done) begin
                    n_add_neg = w_std_neg;
                    if (r_single) begin
                        n_add_mag = {2'b00, w_res[SUM_W-1:0]};
                    end else begin
                        n_add_mag = {1'b0, w_res[SUM_W-1:0], 1'b0};
                    end
                    n_state = S_ACC;
                end
            end
            S_H1SQ: begin
                if (w_done) begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_SQRT;
                    w_req.num   = w_res;
                    n_state     = S_H1RT;
                end
            end
            S_H1RT: begin
                if (w_done) begin
                    w_req.start = 1'b1;
                    w_req.a1    = w_dm;
                    w_req.b1    = w_dm;
                    w_req.a2    = w_d2m;
                    w_req.b2    = w_d2m;
                    n_state     = S_H2SQ;
                end
            end
            S_H2SQ: begin
                if (w_done) begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_SQRT;
                    w_req.num   = w_res;
                    n_state     = S_H2RT;
                end
            end
            S_H2RT: begin
                if (w_done) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                n_add_neg = w_term[DEN_W+1];
                if (r_single) begin
                    n_add_mag = {{(ADD_W-DEN_W-2){1'b0}}, w_term_abs};
                end else begin
                    n_add_mag = {{(ADD_W-DEN_W-3){1'b0}}, w_term_abs, 1'b0};
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input capture, operand preparation and square-root results.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_tab    <= s_axis_tdata[31:0];
            r_tba    <= s_axis_tdata[63:32];
            r_ei     <= s_axis_tdata[95:64];
            r_ej     <= s_axis_tdata[127:96];
            r_ea     <= s_axis_tdata[159:128];
            r_eb     <= s_axis_tdata[191:160];
            r_single <= s_axis_tuser;
            r_last   <= s_axis_tlast;
        end
        if (r_state == S_PREP) begin
            r_den <= DEN_W'(r_ei) + DEN_W'(r_ej) - DEN_W'(r_ea) - DEN_W'(r_eb);
            r_x   <= (COEF_W+2)'(r_tab) + (COEF_W+2)'(r_tab) - (COEF_W+2)'(r_tba);
            r_d2  <= (COEF_W+1)'(r_tab) - (COEF_W+1)'(r_tba);
        end
        if ((r_state == S_H1RT) && w_done) begin
            r_h1 <= w_res[MAG_W-1:0];
        end
        if ((r_state == S_H2RT) && w_done) begin
            r_h2 <= w_res[MAG_W-1:0];
        end
        r_add_mag  <= n_add_mag;
        r_add_neg  <= n_add_neg;
        r_add_skip <= n_add_skip;
    end

    assign s_axis_tready = (r_state == S_IDLE);

    pea_serial_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_busy   (w_busy),
        .o_done   (w_done),
        .o_result (w_res)
    );

    // Term handed to the accumulator.
    always_comb begin
        w_acc.update = w_fire;
        w_acc.skip   = r_add_skip;
        w_acc.neg    = r_add_neg;
        w_acc.last   = r_last;
        w_acc.mag    = r_add_mag;
    end

    pea_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_acc),
        .i_out_ready (m_axis_tready),
        .o_out_hold  (w_hold),
        .o_out_valid (m_axis_tvalid),
        .o_total     (m_axis_tdata[63:0]),
        .o_zero_den  (m_axis_tdata[64]),
        .o_saturated (m_axis_tdata[65])
    );

    assign m_axis_tdata[71:66] = '0;

    // The serial unit is started only when it is free.
    `PEA_ASSERT_NOW(a_start_free, w_req.start, !w_busy)
    // A unit result arrives only while the sequencer waits for one.
    `PEA_ASSERT_NOW(a_done_wait, w_done, (r_state != S_IDLE) && (r_state != S_ACC)
        && (r_state != S_PREP) && (r_state != S_ISSUE) && (r_state != S_TERM))
    // The last item of a set always leaves a result behind.
    `PEA_ASSERT_NEXT(a_emit, w_fire && r_last, m_axis_tvalid)

endmodule

// File: test/pair_energy_accumulator_unit_test.sv
// Self-checking testbench for the pair energy accumulator: directed table, then random sets.
`timescale 1ns / 1ps
module pair_energy_accumulator_unit_test;

    localparam int  CLK_HALF = 4;
    localparam int  SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 64'd2_000_000;
    localparam logic STANDARD_MODE  = 1'b0;
    localparam logic CORRECTED_MODE = 1'b1;
    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    // One pair item as driven on the input stream.
    typedef struct {
        logic signed [31:0] coef_ab;
        logic signed [31:0] coef_ba;
        logic signed [31:0] occ_i;
        logic signed [31:0] occ_j;
        logic signed [31:0] virt_a;
        logic signed [31:0] virt_b;
        logic               single_weight;
        logic               last_term;
    } t_pair;

    // One emitted energy result.
    typedef struct {
        logic signed [63:0] energy_total;
        logic               zero_denominator;
        logic               saturated;
    } t_energy;

    // Directed row: item, and a hand value for the emitted sum where obvious.
    typedef struct {
        t_pair   pair;
        logic    mode;
        logic    known;
        t_energy hand;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    pair_energy_accumulator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Predictor state.
    logic signed [63:0] run_sum;
    logic               run_zero_div;
    logic               run_clipped;
    logic               mode_now;

    t_energy energy_queue[$];
    int      fail_count = 0;
    longint  cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // Saturating add of a signed term into the running sum.
    function automatic void sum_add(input logic signed [66:0] term);
        logic signed [66:0] wide;
        wide = $signed({{3{run_sum[63]}}, run_sum}) + term;
        if (wide > $signed({3'b000, SUM_MAX})) begin
            run_sum = SUM_MAX;
            run_clipped = 1'b1;
        end else if (wide < $signed({3'b111, SUM_MIN})) begin
            run_sum = SUM_MIN;
            run_clipped = 1'b1;
        end else begin
            run_sum = wide[63:0];
        end
    endfunction

    // Floor square root of a sum of two squares.
    function automatic logic [37:0] hyp_root(input logic [35:0] x, input logic [35:0] y);
        logic [77:0] rad;
        logic [37:0] r;
        logic [37:0] c;
        rad = 78'(x) * 78'(x) + 78'(y) * 78'(y);
        r = '0;
        for (int b = 37; b >= 0; b--) begin
            c = r | (38'd1 << b);
            if (78'(c) * 78'(c) <= rad) r = c;
        end
        return r;
    endfunction

    function automatic logic [35:0] mag36(input logic signed [35:0] v);
        return v < 0 ? 36'(-v) : 36'(v);
    endfunction

    // Apply one pair to the predicted sum; queue a result on the last term.
    function automatic void predict_pair(input t_pair p);
        logic signed [35:0]  den, x, diff2, ab2;
        logic [67:0]         q;
        logic signed [66:0]  term;
        logic signed [39:0]  n1, n2, t4, t;
        t_energy             e;
        den = 36'(p.occ_i) + 36'(p.occ_j) - 36'(p.virt_a) - 36'(p.virt_b);
        if (mode_now == STANDARD_MODE) begin
            if (den == 0) begin
                run_zero_div = 1'b1;
                term = '0;
            end else begin
                x = 2 * 36'(p.coef_ab) - 36'(p.coef_ba);
                q = (68'(mag36(36'(p.coef_ab))) * 68'(mag36(x))) / 68'(mag36(den));
                term = (((p.coef_ab < 0) != (x < 0)) != (den < 0)) ? -$signed({1'b0, 66'(q)})
                                                                   : $signed({1'b0, 66'(q)});
            end
        end else begin
            ab2 = 2 * 36'(p.coef_ab);
            diff2 = 2 * (36'(p.coef_ab) - 36'(p.coef_ba));
            n1 = -40'(den) - $signed({2'b0, hyp_root(mag36(den), mag36(ab2))});
            n2 = -40'(den) - $signed({2'b0, hyp_root(mag36(den), mag36(diff2))});
            t4 = 2 * n1 + n2;
            t = t4 >>> 2;
            term = 67'(t);
        end
        if (!(mode_now == STANDARD_MODE && den == 0)) begin
            sum_add(term);
            if (!p.single_weight) sum_add(term);
        end
        if (p.last_term) begin
            e.energy_total = run_sum;
            e.zero_denominator = run_zero_div;
            e.saturated = run_clipped;
            energy_queue = {energy_queue, e};
            run_sum = '0;
            run_zero_div = 1'b0;
            run_clipped = 1'b0;
        end
    endfunction

    // Send one item, idling at random before it; valid stays up between back-to-back items.
    task automatic send_pair(input t_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.virt_b, p.virt_a, p.occ_j, p.occ_i, p.coef_ba, p.coef_ab};
        s_axis_tuser <= p.single_weight;
        s_axis_tlast <= p.last_term;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pair(p);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (energy_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the mode register while the block is idle.
    task automatic write_mode(input logic m);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_now = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(4096)) - 32'd2048;
            3: return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair rand_pair(input int set_left);
        t_pair p;
        p.coef_ab = rand_word();
        p.coef_ba = rand_word();
        p.occ_i = rand_word();
        p.occ_j = rand_word();
        p.virt_a = rand_word();
        // Make the denominator vanish now and then.
        p.virt_b = ($urandom_range(15) == 0) ? p.occ_i + p.occ_j - p.virt_a : rand_word();
        p.single_weight = 1'($urandom_range(1));
        p.last_term = (set_left == 0);
        return p;
    endfunction

    function automatic t_pair mk(input logic [31:0] ab, ba, oi, oj, va, vb,
                                 input logic sw, lt);
        t_pair p;
        p.coef_ab = ab; p.coef_ba = ba; p.occ_i = oi; p.occ_j = oj;
        p.virt_a = va; p.virt_b = vb; p.single_weight = sw; p.last_term = lt;
        return p;
    endfunction

    // Result checker and cycle-limit watchdog.
    always @(posedge i_clk) begin
        t_energy want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pair_energy_accumulator_unit_test: FAIL");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (energy_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                fail_count <= fail_count + 1;
            end else begin
                want = energy_queue.pop_front();
                if (m_axis_tdata[63:0] !== want.energy_total ||
                    m_axis_tdata[64] !== want.zero_denominator ||
                    m_axis_tdata[65] !== want.saturated) begin
                    $display("%0t: expected sum %0d zd %b sat %b, got sum %0d zd %b sat %b",
                             $time, want.energy_total, want.zero_denominator, want.saturated,
                             $signed(m_axis_tdata[63:0]), m_axis_tdata[64], m_axis_tdata[65]);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    initial begin
        t_row rows[$];
        t_row r;
        int   left;
        run_sum = '0; run_zero_div = 1'b0; run_clipped = 1'b0; mode_now = STANDARD_MODE;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; hand values only where the sum is plain to see.
        r.known = 1'b0; r.hand = '{64'sd0, 1'b0, 1'b0};
        r.mode = STANDARD_MODE;
        r.pair = mk(0, 0, 32'h0100_0000, 0, 0, 0, 1'b1, 1'b1); r.known = 1'b1;
        rows = {rows, r};
        r.pair = mk(5, 5, 7, 7, 7, 7, 1'b0, 1'b1); r.hand = '{64'sd0, 1'b1, 1'b0};
        rows = {rows, r};
        r.known = 1'b0;
        r.pair = mk(32'h0100_0000, 0, 32'h0100_0000, 0, 0, 0, 1'b1, 1'b1); rows = {rows, r};
        r.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1, 1'b0, 1'b0); rows = {rows, r};
        r.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1, 1'b0, 1'b0); rows = {rows, r};
        r.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1, 1'b0, 1'b1); rows = {rows, r};
        r.pair = mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1, 1'b0, 1'b0); rows = {rows, r};
        r.pair = mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1, 1'b0, 1'b1); rows = {rows, r};
        r.pair = mk(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1); rows = {rows, r};
        r.pair = mk(32'hFFFF_FFFF, 3, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1); rows = {rows, r};
        r.mode = CORRECTED_MODE;
        r.pair = mk(0, 0, 0, 0, 0, 0, 1'b1, 1'b1); r.known = 1'b1;
        r.hand = '{64'sd0, 1'b0, 1'b0}; rows = {rows, r};
        r.known = 1'b0;
        r.pair = mk(5, 5, 7, 7, 7, 7, 1'b0, 1'b1); rows = {rows, r};
        r.pair = mk(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 32'h0100_0000, 1'b1, 1'b1);
        rows = {rows, r};
        r.pair = mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1); rows = {rows, r};
        r.pair = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0); rows = {rows, r};
        r.pair = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1); rows = {rows, r};
        r.pair = mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 3, 32'h8000_0000, 1, 32'hFFFF_FFFF,
                    1'b1, 1'b1);
        rows = {rows, r};

        foreach (rows[k]) begin
            if (rows[k].mode != mode_now) write_mode(rows[k].mode);
            send_pair(rows[k].pair);
            if (rows[k].known && energy_queue.size() != 0)
                energy_queue[$] = rows[k].hand;
        end
        write_mode(STANDARD_MODE);

        // Random sets over every idling phase and both modes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            write_mode(ph >= 4 ? CORRECTED_MODE : STANDARD_MODE);
            left = $urandom_range(4);
            for (int n = 0; n < 150; n++) begin
                if (n == 75) wait_drained();
                send_pair(rand_pair(left));
                left = (left == 0) ? $urandom_range(6) : left - 1;
            end
            send_pair(rand_pair(0));
        end

        send_idle_pct = 0; recv_stall_pct = 0;
        wait_drained();
        if (fail_count == 0) begin
            $display("pair_energy_accumulator_unit_test: PASS");
        end else begin
            $display("pair_energy_accumulator_unit_test: FAIL");
        end
        $finish;
    end

endmodule
